// ===== sv/patp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and grid lookup functions for the trap phase block.
package patp_pkg;

  localparam int COORD_W  = 16;
  localparam int DIFF_W   = 18;
  localparam int SQ_W     = 35;
  localparam int SUM_W    = 36;
  localparam int ROOT_W   = 26;
  localparam int PAD_W    = 2 * ROOT_W - SUM_W;
  localparam int PH_W     = 32;
  localparam int LANE_LAT = 33;

  // sin(theta) threshold for the first zero of J0, as a cos^2 ratio scaled by 2^24
  localparam logic [23:0] COS2_LIMIT = 24'd9548593;

  // floor(x / 343) = (x * DIV_RECIP) >> DIV_SHIFT for x below 2^48
  localparam int          DIV_SHIFT = 57;
  localparam logic [63:0] DIV_RECIP = ((64'd1 << DIV_SHIFT) + 64'd342) / 64'd343;

  localparam logic [1:0] PANEL_L_HI = 2'd0;
  localparam logic [1:0] PANEL_R_HI = 2'd1;
  localparam logic [1:0] PANEL_L_LO = 2'd2;
  localparam logic [1:0] PANEL_R_LO = 2'd3;

  typedef struct packed {
    logic bottom;
    logic flip;
    logic zero;
  } side_t;

  typedef struct packed {
    logic       vld;
    logic [1:0] on;
  } ctl_t;

  // Column before saturation: channel / 10.
  function automatic logic [2:0] chan_col(input logic [5:0] chan);
    logic [2:0] c;
    c = 3'd0;
    if (chan >= 6'd10) c = 3'd1;
    if (chan >= 6'd20) c = 3'd2;
    if (chan >= 6'd30) c = 3'd3;
    if (chan >= 6'd40) c = 3'd4;
    if (chan >= 6'd50) c = 3'd5;
    if (chan >= 6'd60) c = 3'd6;
    return c;
  endfunction

  function automatic logic signed [15:0] col_pos(input logic [2:0] c);
    logic signed [15:0] p;
    case (c)
      3'd0:    p = 16'sd11520;
      3'd1:    p = 16'sd8960;
      3'd2:    p = 16'sd6400;
      3'd3:    p = 16'sd3840;
      default: p = 16'sd1280;
    endcase
    return p;
  endfunction

  function automatic logic signed [15:0] row_pos(input logic [3:0] r);
    logic signed [15:0] p;
    case (r)
      4'd0:    p = -16'sd11520;
      4'd1:    p = -16'sd8960;
      4'd2:    p = -16'sd6400;
      4'd3:    p = -16'sd3840;
      4'd4:    p = -16'sd1280;
      4'd5:    p = 16'sd1280;
      4'd6:    p = 16'sd3840;
      4'd7:    p = 16'sd6400;
      4'd8:    p = 16'sd8960;
      4'd9:    p = 16'sd11520;
      default: p = 16'sd0;
    endcase
    return p;
  endfunction

endpackage

// ===== sv/patp_sqrt.sv =====
`timescale 1ns / 1ps
// Pipelined integer square root of (radicand << 16), one root bit per stage.
module patp_sqrt import patp_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [SUM_W-1:0]  radicand,
  input  side_t             side_in,
  output logic [ROOT_W-1:0] root,
  output side_t             side_out
);

  logic [SUM_W-1:0]  op  [ROOT_W];
  logic [ROOT_W+3:0] rem [ROOT_W];
  logic [ROOT_W-1:0] q   [ROOT_W];
  side_t             sd  [ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    logic [SUM_W-1:0]    op_in;
    logic [ROOT_W+3:0]   rem_in;
    logic [ROOT_W-1:0]   q_in;
    side_t               sd_in;
    logic [2*ROOT_W-1:0] wide;
    logic [ROOT_W+3:0]   cur;
    logic [ROOT_W+3:0]   trial;
    logic                ge;

    if (i == 0) begin : g_first
      assign op_in  = radicand;
      assign rem_in = '0;
      assign q_in   = '0;
      assign sd_in  = side_in;
    end else begin : g_next
      assign op_in  = op[i-1];
      assign rem_in = rem[i-1];
      assign q_in   = q[i-1];
      assign sd_in  = sd[i-1];
    end

    // bring down the next two radicand bits and try root bit one
    assign wide  = {op_in, {PAD_W{1'b0}}};
    assign cur   = {rem_in[ROOT_W+1:0], wide[2*ROOT_W-1-2*i -: 2]};
    assign trial = {2'b00, q_in, 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        op[i]  <= op_in;
        rem[i] <= ge ? (cur - trial) : cur;
        q[i]   <= {q_in[ROOT_W-2:0], ge};
        sd[i]  <= sd_in;
      end
    end
  end

  assign root     = q[ROOT_W-1];
  assign side_out = sd[ROOT_W-1];

endmodule

// ===== sv/patp_lane.sv =====
`timescale 1ns / 1ps
// One target lane: transducer offset, distance, directivity test and phase.
module patp_lane import patp_pkg::*; (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [COORD_W-1:0] tx,
  input  logic signed [COORD_W-1:0] ty,
  input  logic signed [COORD_W-1:0] tz,
  input  logic [1:0]                board,
  input  logic [5:0]                chan,
  input  logic [15:0]               spacing,
  output logic [PH_W-1:0]           phase
);

  // stage 1: offsets, doubled to 1/512 mm
  logic [2:0]                col_u, col, mir;
  logic [5:0]                row6;
  logic signed [15:0]        ex;
  logic signed [15:0]        rz;
  logic signed [16:0]        dx17, dz17, ty2;
  logic signed [DIFF_W-1:0]  dy_c;
  logic signed [DIFF_W-1:0]  dx2, dy2, dz2;
  logic                      bot1;

  assign col_u = chan_col(chan);
  assign col   = (col_u > 3'd4) ? 3'd4 : col_u;
  assign mir   = 3'd4 - col;
  assign row6  = chan - {col_u, 3'b000} - {2'b00, col_u, 1'b0};

  always_comb begin
    unique case (board)
      PANEL_L_HI: ex = col_pos(col);
      PANEL_R_HI: ex = -col_pos(mir);
      PANEL_L_LO: ex = col_pos(mir);
      default:    ex = -col_pos(col);
    endcase
  end

  assign rz   = row_pos(row6[3:0]);
  assign dx17 = {tx[15], tx} - {ex[15], ex};
  assign dz17 = {tz[15], tz} - {rz[15], rz};
  assign ty2  = {ty, 1'b0};
  assign dy_c = board[1] ? ({ty2[16], ty2} + {2'b00, spacing})
                         : ({ty2[16], ty2} - {2'b00, spacing});

  always_ff @(posedge clk) begin
    if (en) begin
      dx2  <= {dx17, 1'b0};
      dz2  <= {dz17, 1'b0};
      dy2  <= dy_c;
      bot1 <= board[1];
    end
  end

  // stage 2: squares; the normal component is dy with the board's sign
  logic signed [2*DIFF_W-1:0] px, py, pz;
  logic [SQ_W-1:0]            sx, sy, sz;
  logic                       dnle0, bot2;

  assign px = dx2 * dx2;
  assign py = dy2 * dy2;
  assign pz = dz2 * dz2;

  always_ff @(posedge clk) begin
    if (en) begin
      sx    <= px[SQ_W-1:0];
      sy    <= py[SQ_W-1:0];
      sz    <= pz[SQ_W-1:0];
      dnle0 <= bot1 ? (dy2 <= 0) : (dy2 >= 0);
      bot2  <= bot1;
    end
  end

  // stage 3: squared distance
  logic [SUM_W-1:0] sum3;
  logic [SQ_W-1:0]  sy3;
  logic             dnle3, bot3;

  always_ff @(posedge clk) begin
    if (en) begin
      sum3  <= SUM_W'(sx) + SUM_W'(sy) + SUM_W'(sz);
      sy3   <= sy;
      dnle3 <= dnle0;
      bot3  <= bot2;
    end
  end

  // stage 4: threshold product in two halves
  logic [41:0]      plo, phi;
  logic [SUM_W-1:0] sum4;
  logic [SQ_W-1:0]  sy4;
  logic             dnle4, bot4;

  always_ff @(posedge clk) begin
    if (en) begin
      plo   <= COS2_LIMIT * sum3[17:0];
      phi   <= COS2_LIMIT * sum3[35:18];
      sum4  <= sum3;
      sy4   <= sy3;
      dnle4 <= dnle3;
      bot4  <= bot3;
    end
  end

  // stage 5: directivity sign flip
  logic [59:0]      lim, lhs;
  logic             zero4;
  logic [SUM_W-1:0] sum5;
  side_t            side5;

  assign lim   = 60'(plo) + (60'(phi) << 18);
  assign lhs   = 60'(sy4) << 24;
  assign zero4 = (sum4 == '0);

  always_ff @(posedge clk) begin
    if (en) begin
      sum5        <= sum4;
      side5.bottom <= bot4;
      side5.zero   <= zero4;
      side5.flip   <= !zero4 && (dnle4 || (lhs < lim));
    end
  end

  logic [ROOT_W-1:0] path_len;
  side_t             side_r;

  patp_sqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .radicand (sum5),
    .side_in  (side5),
    .root     (path_len),
    .side_out (side_r)
  );

  // divide stage A: (path_len*40*2^15 + 171) times the reciprocal of 343, partials
  logic [28:0] d5;
  logic [47:0] xv;
  logic [47:0] p_ll, p_hl;
  logic [48:0] p_lh, p_hh;
  side_t       side_a;

  assign d5 = 29'(path_len) + (29'(path_len) << 2);
  assign xv = (48'(d5) << 18) + 48'd171;

  always_ff @(posedge clk) begin
    if (en) begin
      p_ll   <= xv[23:0]  * DIV_RECIP[23:0];
      p_lh   <= xv[23:0]  * DIV_RECIP[48:24];
      p_hl   <= xv[47:24] * DIV_RECIP[23:0];
      p_hh   <= xv[47:24] * DIV_RECIP[48:24];
      side_a <= side_r;
    end
  end

  // divide stage B: quotient, negate, add half turns
  logic [96:0]     tot;
  logic [PH_W-1:0] num, pneg;

  assign tot  = 97'(p_ll) + (97'(p_lh) << 24) + (97'(p_hl) << 24) + (97'(p_hh) << 48);
  assign num  = tot[DIV_SHIFT +: PH_W];
  assign pneg = side_a.zero ? '0 : (PH_W'(0) - num);

  always_ff @(posedge clk) begin
    if (en) begin
      phase <= pneg + {side_a.flip ^ side_a.bottom, {(PH_W-1){1'b0}}};
    end
  end

endmodule

// ===== sv/patp_merge.sv =====
`timescale 1ns / 1ps
// Merge of the lane phases: phasor-sum angle, then rounding to ticks.
module patp_merge import patp_pkg::*; #(
  parameter int PHASE_STEPS = 256
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  ctl_t            ctl,
  input  logic [PH_W-1:0] phase_a,
  input  logic [PH_W-1:0] phase_b,
  output logic            out_valid,
  output logic [7:0]      phase_ticks
);

  localparam int SW = $clog2(PHASE_STEPS + 1);

  logic [PH_W-1:0] diff, half, res_c, res;
  logic            none, vld1;

  // halve the signed difference, dropping the fraction toward phase_a
  assign diff  = phase_b - phase_a;
  assign half  = diff[PH_W-1] ? (PH_W'(0) - ((PH_W'(0) - diff) >> 1)) : (diff >> 1);
  assign res_c = (ctl.on[0] && ctl.on[1]) ? (phase_a + half) :
                 ctl.on[0] ? phase_a : phase_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else if (en) begin
      vld1 <= ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res  <= res_c;
      none <= !ctl.on[0] && !ctl.on[1];
    end
  end

  logic [PH_W+SW-1:0] prod;
  logic [PH_W+SW:0]   rnd;
  logic [SW:0]        tk;
  logic               wrap;

  assign prod = (PH_W+SW)'(res) * (PH_W+SW)'(PHASE_STEPS);
  assign rnd  = (PH_W+SW+1)'(prod) + ((PH_W+SW+1)'(1) << (PH_W-1));
  assign tk   = rnd[PH_W +: SW+1];
  assign wrap = (tk >= (SW+1)'(PHASE_STEPS));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      phase_ticks <= (none || wrap) ? 8'd0 : 8'(tk);
    end
  end

endmodule

// ===== sv/phased_array_trap_phase.sv =====
`timescale 1ns / 1ps
// Top level of the trap phase block: config register, lanes, control chain, merge.
// Throughput: one beat per cycle unless the output stalls; each target has its own
// lane, the square root is a 26-stage pipeline with one root bit per stage.
// A stalled output holds the whole pipeline; in_ready is low only then.
// Synchronous reset empties the pipeline and sets board_spacing to 34560.
module phased_array_trap_phase import patp_pkg::*; #(
  parameter int PHASE_STEPS = 256,
  parameter int NUM_TARGETS = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] first_x,
  input  logic [15:0] first_y,
  input  logic [15:0] first_z,
  input  logic        first_on,
  input  logic [15:0] second_x,
  input  logic [15:0] second_y,
  input  logic [15:0] second_z,
  input  logic        second_on,
  input  logic [1:0]  board_index,
  input  logic [5:0]  channel_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  phase_ticks
);

  logic        en;
  logic [15:0] board_spacing;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      board_spacing <= 16'd34560;
    end else if (cfg_we) begin
      board_spacing <= cfg_wdata;
    end
  end

  // track valid and enables alongside the lanes
  ctl_t ctl_q [LANE_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LANE_LAT; i++) ctl_q[i] <= '0;
    end else if (en) begin
      ctl_q[0] <= '{vld: in_valid, on: {(NUM_TARGETS > 1) && second_on, first_on}};
      for (int i = 1; i < LANE_LAT; i++) ctl_q[i] <= ctl_q[i-1];
    end
  end

  logic signed [COORD_W-1:0] tx [2];
  logic signed [COORD_W-1:0] ty [2];
  logic signed [COORD_W-1:0] tz [2];
  logic [PH_W-1:0]           phase [2];

  assign tx[0] = first_x;
  assign ty[0] = first_y;
  assign tz[0] = first_z;
  assign tx[1] = second_x;
  assign ty[1] = second_y;
  assign tz[1] = second_z;

  for (genvar g = 0; g < 2; g++) begin : g_lane
    if (g < NUM_TARGETS) begin : g_on
      patp_lane u_lane (
        .clk     (clk),
        .en      (en),
        .tx      (tx[g]),
        .ty      (ty[g]),
        .tz      (tz[g]),
        .board   (board_index),
        .chan    (channel_index),
        .spacing (board_spacing),
        .phase   (phase[g])
      );
    end else begin : g_off
      assign phase[g] = '0;
    end
  end

  patp_merge #(
    .PHASE_STEPS (PHASE_STEPS)
  ) u_merge (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .ctl         (ctl_q[LANE_LAT-1]),
    .phase_a     (phase[0]),
    .phase_b     (phase[1]),
    .out_valid   (out_valid),
    .phase_ticks (phase_ticks)
  );

endmodule

// ===== sv/patp_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the trap phase block, bound to the top level.
module patp_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] phase_ticks
);

  // a waiting result beat holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(phase_ticks))
    else $error("result beat changed while stalled");

  // input side is held back only by a stalled result
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output stall");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result beat right after reset");

  // a stalled pipeline takes no new beat
  a_no_take: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

endmodule

bind phased_array_trap_phase patp_checker u_patp_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .phase_ticks (phase_ticks)
);
